>>> rtl/core/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and the ordering function of the priority sort
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

	localparam int ID_W     = 16;
	localparam int WEIGHT_W = 32;
	localparam int POS_W    = 6;
	localparam int BATCH_W  = 7;
	localparam int DUP_W    = 6;
	localparam int EPS_W    = 31;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 48;

	// configuration register indexes
	localparam logic CFG_ZERO_EPSILON = 1'b0;
	localparam logic CFG_TIE_BREAK    = 1'b1;

	// cell operation codes
	localparam logic [1:0] MODE_HOLD  = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_SORT  = 2'd2;
	localparam logic [1:0] MODE_DRAIN = 2'd3;

	typedef struct packed {
		logic                       valid;
		logic [ID_W-1:0]            id;
		logic signed [WEIGHT_W-1:0] weight;
		logic [POS_W-1:0]           pos;
	} entry_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       odd_phase;
		logic       by_index;
	} cell_ctl_t;

	// true when entry a has to come before entry b in the sorted run
	function automatic logic goes_before(entry_t a, entry_t b, logic by_index);
		logic res;
		if (!a.valid) begin
			res = 1'b0;
		end else if (!b.valid) begin
			res = 1'b1;
		end else if (a.weight != b.weight) begin
			res = (a.weight > b.weight);
		end else if (by_index && (a.id != b.id)) begin
			res = (a.id < b.id);
		end else begin
			res = (a.pos < b.pos);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/priority_sort_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_sort_scheduler_top
// Loads a batch into a chain of cells, sorts it by odd-even transposition
// and streams the item ids out in descending weight with batch metrics.
// ----------------------------------------------------------------------------
// throughput: one input transaction per cycle while a batch loads
// sorting: n sort rounds of the cell chain (one per cycle, n = stored items),
//   first result in the cycle after the last round, then one result per cycle while m_tready is high
// reset: asynchronous, clears the chain valid bits, tallies and registers
`default_nettype none

module priority_sort_scheduler_top #(
	parameter int MAX_ITEMS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	// s_tdata: item_id [15:0], weight [47:16]
	input  wire [47:0] s_tdata,
	input  wire        s_tlast,
	input  wire        s_tvalid,
	output logic       s_tready,
	// m_tdata: sorted_id [15:0], batch_count [22:16], duplicate_count [28:23],
	//   zero_count [35:29], moved_count [42:36], overflow [43], zero fill [47:44]
	output logic [47:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [30:0] cfg_wdata
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam logic [pss_pkg::BATCH_W-1:0] CAPACITY = pss_pkg::BATCH_W'(MAX_ITEMS);

	logic [1:0]                     state_q;
	logic [pss_pkg::EPS_W-1:0]      eps_q;
	logic                           tie_q;
	logic [pss_pkg::BATCH_W-1:0]    fill_q;
	logic [pss_pkg::DUP_W-1:0]      dup_q;
	logic [pss_pkg::BATCH_W-1:0]    zero_q;
	logic [pss_pkg::BATCH_W-1:0]    moved_q;
	logic                           ovf_q;
	logic [pss_pkg::BATCH_W-1:0]    rnd_q;
	logic [pss_pkg::BATCH_W-1:0]    idx_q;
	logic [MAX_ITEMS-1:0]           match_s1;
	logic                           load_s1;

	logic [pss_pkg::ID_W-1:0]            in_id;
	logic signed [pss_pkg::WEIGHT_W-1:0] in_weight;
	logic [pss_pkg::WEIGHT_W-1:0]        in_mag;
	logic                                in_zero;
	logic                                in_acc;
	logic                                full;
	logic                                store;
	logic                                out_acc;
	logic                                out_last;
	logic                                out_moved;
	logic [pss_pkg::BATCH_W-1:0]         moved_total;
	logic [MAX_ITEMS-1:0]                match;

	pss_pkg::cell_ctl_t ctl;
	pss_pkg::entry_t    new_entry;
	pss_pkg::entry_t    ent [MAX_ITEMS];
	logic [MAX_ITEMS-1:0] swap;

	assign in_id     = s_tdata[15:0];
	assign in_weight = s_tdata[47:16];
	assign in_mag    = in_weight[pss_pkg::WEIGHT_W-1] ? (~in_weight + 1'b1) : in_weight;
	// the most negative weight gives 2^31, always above a 31-bit epsilon
	assign in_zero   = (in_mag <= {1'b0, eps_q});

	assign s_tready = (state_q == ST_LOAD);
	assign in_acc   = s_tvalid && s_tready;
	assign full     = (fill_q == CAPACITY);
	assign store    = in_acc && !full;

	assign m_tvalid = (state_q == ST_OUT);
	assign out_acc  = m_tvalid && m_tready;
	assign out_last = (idx_q == (fill_q - 1'b1));

	always_comb begin
		new_entry.valid  = 1'b1;
		new_entry.id     = in_id;
		new_entry.weight = in_weight;
		new_entry.pos    = fill_q[pss_pkg::POS_W-1:0];
	end

	always_comb begin
		ctl.by_index  = tie_q;
		ctl.odd_phase = rnd_q[0];
		if (store) begin
			ctl.mode = pss_pkg::MODE_LOAD;
		end else if (state_q == ST_SORT) begin
			ctl.mode = pss_pkg::MODE_SORT;
		end else if (out_acc) begin
			ctl.mode = pss_pkg::MODE_DRAIN;
		end else begin
			ctl.mode = pss_pkg::MODE_HOLD;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			pss_pkg::entry_t left_e;
			pss_pkg::entry_t right_e;
			logic            swap_l;

			if (gi == 0) begin : g_head
				assign left_e = new_entry;
				assign swap_l = 1'b0;
			end else begin : g_body
				assign left_e = ent[gi-1];
				assign swap_l = swap[gi-1];
			end

			if (gi == MAX_ITEMS - 1) begin : g_tail
				assign right_e = '0;
			end else begin : g_inner
				assign right_e = ent[gi+1];
			end

			pss_cell #(
				.PARITY (gi % 2 == 1)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.left_entry  (left_e),
				.right_entry (right_e),
				.swap_in     (swap_l),
				.swap_out    (swap[gi]),
				.entry       (ent[gi])
			);

			assign match[gi] = ent[gi].valid && (ent[gi].id == in_id);
		end
	endgenerate

	assign out_moved   = (ent[0].pos != idx_q[pss_pkg::POS_W-1:0]);
	assign moved_total = moved_q + pss_pkg::BATCH_W'(out_moved);

	always_comb begin
		m_tdata        = '0;
		m_tdata[15:0]  = ent[0].id;
		m_tlast        = out_last;
		if (out_last) begin
			m_tdata[22:16] = fill_q;
			m_tdata[28:23] = dup_q;
			m_tdata[35:29] = zero_q;
			m_tdata[42:36] = moved_total;
			m_tdata[43]    = ovf_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
			tie_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				pss_pkg::CFG_ZERO_EPSILON: eps_q <= cfg_wdata;
				pss_pkg::CFG_TIE_BREAK:    tie_q <= cfg_wdata[0];
				default:                   eps_q <= eps_q;
			endcase
		end
	end

	// duplicate search result is folded into the tally in the cycle after load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1 <= 1'b0;
		end else begin
			load_s1 <= store;
		end
	end

	always_ff @(posedge clk) begin
		match_s1 <= match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			dup_q   <= '0;
			zero_q  <= '0;
			moved_q <= '0;
			ovf_q   <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (load_s1 && (|match_s1)) begin
				dup_q <= dup_q + 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					if (store) begin
						fill_q <= fill_q + 1'b1;
						if (in_zero) begin
							zero_q <= zero_q + 1'b1;
						end
					end
					if (in_acc && full) begin
						ovf_q <= 1'b1;
					end
					if (in_acc && s_tlast) begin
						state_q <= ST_SORT;
						rnd_q   <= '0;
					end
				end
				ST_SORT: begin
					// n rounds of odd-even transposition order n entries
					if (rnd_q == (fill_q - 1'b1)) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
						moved_q <= '0;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (out_last) begin
							state_q <= ST_LOAD;
							fill_q  <= '0;
							dup_q   <= '0;
							zero_q  <= '0;
							ovf_q   <= 1'b0;
						end else begin
							idx_q   <= idx_q + 1'b1;
							moved_q <= moved_total;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pss_cell.sv
// ----------------------------------------------------------------------------
// pss_cell
// One slot of the sort chain: shifts in on load, compare-exchanges with a
// neighbour while sorting and shifts towards the head while draining.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_cell #(
	parameter bit PARITY = 1'b0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire pss_pkg::cell_ctl_t ctl,
	input  wire pss_pkg::entry_t    left_entry,
	input  wire pss_pkg::entry_t    right_entry,
	input  wire                     swap_in,
	output logic                    swap_out,
	output pss_pkg::entry_t         entry
);

	logic                                valid_q;
	logic [pss_pkg::ID_W-1:0]            id_q;
	logic signed [pss_pkg::WEIGHT_W-1:0] weight_q;
	logic [pss_pkg::POS_W-1:0]           pos_q;
	logic                                is_left;
	logic                                take_left;
	logic                                take_right;

	always_comb begin
		entry.valid  = valid_q;
		entry.id     = id_q;
		entry.weight = weight_q;
		entry.pos    = pos_q;
	end

	// this cell is the lower slot of an active pair in the current round
	assign is_left = (ctl.mode == pss_pkg::MODE_SORT) && (ctl.odd_phase == PARITY);
	assign swap_out = is_left && pss_pkg::goes_before(right_entry, entry, ctl.by_index);

	assign take_left  = (ctl.mode == pss_pkg::MODE_LOAD) ||
		((ctl.mode == pss_pkg::MODE_SORT) && !is_left && swap_in);
	assign take_right = (ctl.mode == pss_pkg::MODE_DRAIN) || swap_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_left) begin
			valid_q <= left_entry.valid;
		end else if (take_right) begin
			valid_q <= right_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			id_q     <= left_entry.id;
			weight_q <= left_entry.weight;
			pos_q    <= left_entry.pos;
		end else if (take_right) begin
			id_q     <= right_entry.id;
			weight_q <= right_entry.weight;
			pos_q    <= right_entry.pos;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks of the priority sort scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        s_tlast,
	input wire [47:0] m_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire        m_tlast
);

	// loading and draining never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while results are pending");

	// a closing input transaction stops intake for the sort
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (!s_tready && !m_tvalid))
		else $error("intake or output active right after batch close");

	// the last result ends the run and reopens intake
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("run did not end after the last result");

	// metrics are only carried on the last result
	a_metrics_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[47:16] == 32'd0))
		else $error("metrics on a result other than the last");

	// the last result always reports at least one item
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[22:16] != 7'd0))
		else $error("empty batch reported");

endmodule

bind priority_sort_scheduler_top pss_checker u_pss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tlast  (m_tlast)
);

`default_nettype wire
